@@ rtl/keyframe_interval_sampler_top_assert.svh @@
// Assertion macros shared by the RTL of the keyframe interval sampler.
// KIS_ASSERT checks a property, KIS_NEVER checks that a condition never holds.
`ifndef KEYFRAME_INTERVAL_SAMPLER_TOP_ASSERT_SVH
`define KEYFRAME_INTERVAL_SAMPLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KIS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define KIS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define KIS_ASSERT(lbl, clk, rst, prop, msg)
`define KIS_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ rtl/kis_pkg.sv @@
`default_nettype none
package kis_pkg;

   localparam int KEYS        = 256;
   localparam int FRAC_BITS   = 16;
   localparam int KEY_IDX_W   = $clog2(KEYS);
   localparam int KEY_COUNT_W = KEY_IDX_W + 1;
   localparam int TIME_W      = 32;
   localparam int DELTA_W     = 31;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int DIV_W       = TIME_W + FRAC_BITS;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OPC_LOAD   = 2'd0;
   localparam opcode_type OPC_TICK   = 2'd1;
   localparam opcode_type OPC_REWIND = 2'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_PLAYBACK_MODE = 1'b0;
   localparam csr_index_type CSR_KEY_COUNT     = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_TICK,
      KIND_REWIND
   } item_kind_type;

   typedef struct packed {
      item_kind_type        kind;
      logic [KEY_IDX_W-1:0] key_index;
      logic [TIME_W-1:0]    key_time;
      logic [DELTA_W-1:0]   delta_time;
   } item_type;

   typedef struct packed {
      logic              go;
      logic [DIV_W-1:0]  dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [TIME_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

@@ rtl/kis_front.sv @@
`default_nettype none
module kis_front import kis_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  opcode_type             req_opcode,
   input  logic [KEY_IDX_W-1:0]   req_key_index,
   input  logic [TIME_W-1:0]      req_key_time,
   input  logic [DELTA_W-1:0]     req_delta_time,
   input  queue_status_type       queue_status,
   output logic                   busy,
   output logic                   push,
   output item_type               push_item
);

   logic          front_valid_ff;
   logic          front_valid_in;
   item_type      front_item_ff;
   item_type      front_item_in;
   logic          accept;
   logic          decoded_valid;
   item_kind_type decoded_kind;

   // Unknown opcodes are dropped here and never reach the queue.
   always_comb begin
      decoded_valid = 1'b1;
      decoded_kind  = KIND_LOAD;
      unique case (req_opcode)
         OPC_LOAD:   decoded_kind = KIND_LOAD;
         OPC_TICK:   decoded_kind = KIND_TICK;
         OPC_REWIND: decoded_kind = KIND_REWIND;
         default:    decoded_valid = 1'b0;
      endcase
   end

   assign busy   = front_valid_ff && queue_status.full;
   assign accept = start && !busy;
   assign push   = front_valid_ff && !queue_status.full;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_item_in  = front_item_ff;
      if (push) begin
         front_valid_in = 1'b0;
      end
      if (accept) begin
         front_valid_in           = decoded_valid;
         front_item_in.kind       = decoded_kind;
         front_item_in.key_index  = req_key_index;
         front_item_in.key_time   = req_key_time;
         front_item_in.delta_time = req_delta_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_item_ff <= front_item_in;
   end

   assign push_item = front_item_ff;

endmodule
`default_nettype wire

@@ rtl/kis_queue.sv @@
`default_nettype none
`include "keyframe_interval_sampler_top_assert.svh"
module kis_queue import kis_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output queue_status_type status,
   output item_type         head
);

   item_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QCOUNT_W-1:0]   count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCOUNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCOUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   `KIS_ASSERT(a_count_bound, clock, reset, count_ff <= QCOUNT_W'(QUEUE_DEPTH), "queue overfilled")
   `KIS_NEVER(a_no_push_full, clock, reset, push && status.full, "word pushed into full queue")
   `KIS_NEVER(a_no_pop_empty, clock, reset, pop && status.empty, "word popped from empty queue")

endmodule
`default_nettype wire

@@ rtl/kis_divider.sv @@
`default_nettype none
module kis_divider import kis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     dq_ff;
   logic [TIME_W-1:0]    rem_ff;
   logic [TIME_W-1:0]    divisor_ff;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;
   logic                 fits;

   // Restoring division, one quotient bit per cycle. The dividend shifts out
   // of the top of dq_ff while quotient bits shift in at the bottom.
   assign trial = {rem_ff, dq_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.go) begin
         dq_ff      <= req.dividend;
         rem_ff     <= '0;
         divisor_ff <= req.divisor;
      end else if (busy_ff) begin
         dq_ff  <= {dq_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dq_ff;
   assign rsp.remainder = rem_ff;

endmodule
`default_nettype wire

@@ rtl/kis_back.sv @@
`default_nettype none
`include "keyframe_interval_sampler_top_assert.svh"
module kis_back import kis_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  queue_status_type       queue_status,
   input  item_type               head,
   output logic                   pop,
   output div_req_type            div_req,
   input  div_rsp_type            div_rsp,
   output logic                   rsp_valid,
   output logic [KEY_IDX_W-1:0]   rsp_first_key,
   output logic [KEY_IDX_W-1:0]   rsp_second_key,
   output logic [FRAC_W-1:0]      rsp_fraction,
   output logic                   rsp_clamped
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH0,
      S_FETCHL,
      S_CLASS,
      S_MOD,
      S_SADDR,
      S_SCMP,
      S_DIV,
      S_EMIT
   } state_type;

   state_type                state_ff;
   logic                     mode_ff;
   logic [KEY_COUNT_W-1:0]   key_count_ff;
   logic signed [TIME_W-1:0] play_time_ff;
   logic [DELTA_W-1:0]       delta_ff;
   logic signed [TIME_W-1:0] start_ff;
   logic signed [TIME_W-1:0] t_ff;
   logic signed [TIME_W-1:0] prev_ff;
   logic [TIME_W-1:0]        len_ff;
   logic                     neg_ff;
   logic [KEY_COUNT_W-1:0]   idx_ff;
   logic                     div_go_ff;
   logic [DIV_W-1:0]         dvd_ff;
   logic [TIME_W-1:0]        dvs_ff;
   logic                     rsp_valid_ff;
   logic [KEY_IDX_W-1:0]     rsp_first_ff;
   logic [KEY_IDX_W-1:0]     rsp_second_ff;
   logic [FRAC_W-1:0]        rsp_fraction_ff;
   logic                     rsp_clamped_ff;

   logic signed [TIME_W-1:0] key_mem [KEYS];
   logic signed [TIME_W-1:0] rdata_ff;
   logic [KEY_IDX_W-1:0]     rd_addr;

   logic [KEY_COUNT_W-1:0]   n_keys;
   logic [KEY_COUNT_W-1:0]   last_w;
   logic [KEY_IDX_W-1:0]     last_key;
   logic [KEY_COUNT_W-1:0]   idx_next;
   logic [TIME_W:0]          len_w;
   logic [TIME_W:0]          diff_w;
   logic [TIME_W:0]          mag_w;
   logic [TIME_W-1:0]        wrap_r;
   logic [TIME_W:0]          wrap_t;
   logic [TIME_W:0]          num_w;
   logic [TIME_W:0]          den_w;
   logic [TIME_W:0]          sum_w;
   logic signed [TIME_W-1:0] advanced;

   // A key count of zero acts as one key, a count beyond the table as all keys.
   always_comb begin
      if (key_count_ff == '0) begin
         n_keys = KEY_COUNT_W'(1);
      end else if (key_count_ff > KEY_COUNT_W'(KEYS)) begin
         n_keys = KEY_COUNT_W'(KEYS);
      end else begin
         n_keys = key_count_ff;
      end
   end

   assign last_w   = n_keys - KEY_COUNT_W'(1);
   assign last_key = last_w[KEY_IDX_W-1:0];
   assign idx_next = idx_ff + KEY_COUNT_W'(1);

   assign len_w  = {rdata_ff[TIME_W-1], rdata_ff} - {start_ff[TIME_W-1], start_ff};
   assign diff_w = {play_time_ff[TIME_W-1], play_time_ff} - {start_ff[TIME_W-1], start_ff};
   assign mag_w  = diff_w[TIME_W] ? (~diff_w + (TIME_W+1)'(1)) : diff_w;

   // Floor modulo: a negative offset with a nonzero remainder folds up by len.
   assign wrap_r = (neg_ff && (div_rsp.remainder != '0)) ? (len_ff - div_rsp.remainder)
                                                        : div_rsp.remainder;
   assign wrap_t = {start_ff[TIME_W-1], start_ff} + {1'b0, wrap_r};

   assign num_w = {t_ff[TIME_W-1], t_ff} - {prev_ff[TIME_W-1], prev_ff};
   assign den_w = {rdata_ff[TIME_W-1], rdata_ff} - {prev_ff[TIME_W-1], prev_ff};

   assign sum_w    = {play_time_ff[TIME_W-1], play_time_ff} + {2'b00, delta_ff};
   assign advanced = (sum_w[TIME_W:TIME_W-1] == 2'b01) ? {1'b0, {(TIME_W-1){1'b1}}}
                                                       : sum_w[TIME_W-1:0];

   assign pop = (state_ff == S_IDLE) && !queue_status.empty;

   always_comb begin
      unique case (state_ff)
         S_FETCH0: rd_addr = '0;
         S_FETCHL: rd_addr = last_key;
         S_SADDR:  rd_addr = idx_ff[KEY_IDX_W-1:0];
         default:  rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop && (head.kind == KIND_LOAD)) begin
         key_mem[head.key_index] <= head.key_time;
      end
      rdata_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         key_count_ff <= KEY_COUNT_W'(1);
         play_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PLAYBACK_MODE: mode_ff      <= csr_wdata[0];
               CSR_KEY_COUNT:     key_count_ff <= csr_wdata[KEY_COUNT_W-1:0];
               default:           ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!queue_status.empty) begin
                  if (head.kind == KIND_REWIND) begin
                     play_time_ff <= '0;
                  end else if (head.kind == KIND_TICK) begin
                     delta_ff <= head.delta_time;
                     state_ff <= S_FETCH0;
                  end
               end
            end
            S_FETCH0: begin
               state_ff <= S_FETCHL;
            end
            S_FETCHL: begin
               start_ff <= rdata_ff;
               state_ff <= S_CLASS;
            end
            S_CLASS: begin
               // Here rdata_ff holds the last key in use.
               if (!mode_ff) begin
                  if (play_time_ff <= start_ff) begin
                     rsp_first_ff    <= '0;
                     rsp_second_ff   <= '0;
                     rsp_fraction_ff <= '0;
                     rsp_clamped_ff  <= 1'b1;
                     state_ff        <= S_EMIT;
                  end else if (play_time_ff >= rdata_ff) begin
                     rsp_first_ff    <= last_key;
                     rsp_second_ff   <= last_key;
                     rsp_fraction_ff <= '0;
                     rsp_clamped_ff  <= 1'b1;
                     state_ff        <= S_EMIT;
                  end else begin
                     t_ff     <= play_time_ff;
                     idx_ff   <= '0;
                     state_ff <= S_SADDR;
                  end
               end else if (len_w[TIME_W] || (len_w == '0)) begin
                  rsp_first_ff    <= '0;
                  rsp_second_ff   <= '0;
                  rsp_fraction_ff <= '0;
                  rsp_clamped_ff  <= 1'b1;
                  state_ff        <= S_EMIT;
               end else begin
                  len_ff    <= len_w[TIME_W-1:0];
                  neg_ff    <= diff_w[TIME_W];
                  div_go_ff <= 1'b1;
                  dvd_ff    <= {{FRAC_BITS{1'b0}}, mag_w[TIME_W-1:0]};
                  dvs_ff    <= len_w[TIME_W-1:0];
                  state_ff  <= S_MOD;
               end
            end
            S_MOD: begin
               if (div_rsp.done) begin
                  t_ff     <= wrap_t[TIME_W-1:0];
                  idx_ff   <= '0;
                  state_ff <= S_SADDR;
               end
            end
            S_SADDR: begin
               state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (rdata_ff < t_ff) begin
                  prev_ff <= rdata_ff;
                  if (idx_next == n_keys) begin
                     rsp_first_ff    <= last_key;
                     rsp_second_ff   <= last_key;
                     rsp_fraction_ff <= '0;
                     rsp_clamped_ff  <= 1'b1;
                     state_ff        <= S_EMIT;
                  end else begin
                     idx_ff   <= idx_next;
                     state_ff <= S_SADDR;
                  end
               end else if (idx_ff == '0) begin
                  // The time sits exactly on the first key.
                  rsp_first_ff    <= '0;
                  rsp_second_ff   <= '0;
                  rsp_fraction_ff <= '0;
                  rsp_clamped_ff  <= 1'b0;
                  state_ff        <= S_EMIT;
               end else begin
                  div_go_ff      <= 1'b1;
                  dvd_ff         <= {num_w[TIME_W-1:0], {FRAC_BITS{1'b0}}};
                  dvs_ff         <= den_w[TIME_W-1:0];
                  rsp_first_ff   <= idx_ff[KEY_IDX_W-1:0] - KEY_IDX_W'(1);
                  rsp_second_ff  <= idx_ff[KEY_IDX_W-1:0];
                  rsp_clamped_ff <= 1'b0;
                  state_ff       <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  rsp_fraction_ff <= div_rsp.quotient[FRAC_W-1:0];
                  state_ff        <= S_EMIT;
               end
            end
            S_EMIT: begin
               rsp_valid_ff <= 1'b1;
               play_time_ff <= advanced;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign div_req.go       = div_go_ff;
   assign div_req.dividend = dvd_ff;
   assign div_req.divisor  = dvs_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_first_key  = rsp_first_ff;
   assign rsp_second_key = rsp_second_ff;
   assign rsp_fraction   = rsp_fraction_ff;
   assign rsp_clamped    = rsp_clamped_ff;

   `KIS_ASSERT(a_word_single, clock, reset, rsp_valid_ff |=> !rsp_valid_ff, "result word held over")
   `KIS_ASSERT(a_clamp_no_frac, clock, reset, (rsp_valid_ff && rsp_clamped_ff) |-> (rsp_fraction_ff == '0), "clamped word with fraction")
   `KIS_ASSERT(a_key_pair, clock, reset, rsp_valid_ff |-> ((rsp_second_ff == rsp_first_ff) || (rsp_second_ff == rsp_first_ff + KEY_IDX_W'(1))), "key pair not adjacent")
   `KIS_NEVER(a_div_wait_no_go, clock, reset, div_go_ff && (state_ff != S_MOD) && (state_ff != S_DIV), "divider started outside a wait state")

endmodule
`default_nettype wire

@@ rtl/keyframe_interval_sampler_top.sv @@
// Keyframe interval sampler.
// Command words enter on start/req_* and are taken at a clock edge where start
// is high and busy is low. Opcode 0 loads req_key_time into slot req_key_index,
// opcode 1 samples the track at the play time and then advances it by
// req_delta_time, opcode 2 rewinds the play time to zero; opcode 3 is dropped.
// Each tick gives one result word on rsp_*, marked by rsp_valid for exactly one
// cycle; the receiver cannot hold it off. Loads and rewinds give no word.
// The csr port sets playback mode (index 0) and key count (index 1); the user
// must write it only while idle, which the block itself does not enforce.
// A four-word queue separates the command register from the executing side, so
// busy rises only while that queue is full. The time a tick takes grows with
// the linear key search over the single key-table read port, with the serial
// interpolation divide when the time falls between keys and with the serial
// wrap modulo in looping mode. Loads and rewinds retire when the idle back end
// pops them. Words execute strictly one after another.
// Reset clears the play time, selects one-shot mode and a key count of one;
// the key table holds no defined value until loaded.
`default_nettype none
module keyframe_interval_sampler_top import kis_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  opcode_type             req_opcode,
   input  logic [KEY_IDX_W-1:0]   req_key_index,
   input  logic signed [TIME_W-1:0] req_key_time,
   input  logic [DELTA_W-1:0]     req_delta_time,
   output logic                   rsp_valid,
   output logic [KEY_IDX_W-1:0]   rsp_first_key,
   output logic [KEY_IDX_W-1:0]   rsp_second_key,
   output logic [FRAC_W-1:0]      rsp_fraction,
   output logic                   rsp_clamped,
   input  logic                   csr_we,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   queue_status_type queue_status;
   logic             push;
   item_type         push_item;
   logic             pop;
   item_type         head;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   kis_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_opcode     (req_opcode),
      .req_key_index  (req_key_index),
      .req_key_time   (req_key_time),
      .req_delta_time (req_delta_time),
      .queue_status   (queue_status),
      .busy           (busy),
      .push           (push),
      .push_item      (push_item)
   );

   kis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .status    (queue_status),
      .head      (head)
   );

   kis_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   kis_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .queue_status   (queue_status),
      .head           (head),
      .pop            (pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_first_key  (rsp_first_key),
      .rsp_second_key (rsp_second_key),
      .rsp_fraction   (rsp_fraction),
      .rsp_clamped    (rsp_clamped)
   );

endmodule
`default_nettype wire

@@ tb/keyframe_interval_sampler_checker.sv @@
`default_nettype none
module keyframe_interval_sampler_checker import kis_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  opcode_type               req_opcode,
   input  logic [KEY_IDX_W-1:0]     req_key_index,
   input  logic signed [TIME_W-1:0] req_key_time,
   input  logic [DELTA_W-1:0]       req_delta_time,
   input  logic                     rsp_valid,
   input  logic [KEY_IDX_W-1:0]     rsp_first_key,
   input  logic [KEY_IDX_W-1:0]     rsp_second_key,
   input  logic [FRAC_W-1:0]        rsp_fraction,
   input  logic                     rsp_clamped,
   input  logic                     csr_we,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       pending_words,
   output int                       mismatch_count,
   output int                       words_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [KEY_IDX_W-1:0] first_key;
      logic [KEY_IDX_W-1:0] second_key;
      logic [FRAC_W-1:0]    fraction;
      logic                 clamped;
   } sample_word_type;

   logic signed [TIME_W-1:0] track_keys [KEYS];
   logic signed [TIME_W-1:0] track_time;
   logic                     looping;
   logic [CSR_DATA_W-1:0]    key_count;
   sample_word_type          expected_samples [$];

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("%0t: mismatch on result word %0d: %s", $time, words_checked, what);
   endtask

   function automatic sample_word_type make_word(input int first, input int second,
                                                  input longint frac, input bit clamped);
      sample_word_type word;
      word.first_key  = first[KEY_IDX_W-1:0];
      word.second_key = second[KEY_IDX_W-1:0];
      word.fraction   = frac[FRAC_W-1:0];
      word.clamped    = clamped;
      return word;
   endfunction

   // Works out what a tick reports for the current play time and table.
   function automatic sample_word_type sample_track();
      int     n;
      int     last;
      int     i;
      longint first_t;
      longint last_t;
      longint t;
      longint span;
      longint r;
      longint k0;
      longint k1;
      if (key_count == 0) begin
         n = 1;
      end else if (key_count > KEYS) begin
         n = KEYS;
      end else begin
         n = int'(key_count);
      end
      last    = n - 1;
      first_t = longint'(track_keys[0]);
      last_t  = longint'(track_keys[last]);
      t       = longint'(track_time);
      if (!looping) begin
         if (t <= first_t) return make_word(0, 0, 0, 1'b1);
         if (t >= last_t) return make_word(last, last, 0, 1'b1);
      end else begin
         span = last_t - first_t;
         if (span <= 0) return make_word(0, 0, 0, 1'b1);
         // Floor modulo: the remainder is pulled into [0, span).
         r = (t - first_t) % span;
         if (r < 0) r += span;
         t = first_t + r;
      end
      i = 0;
      while (i < n && longint'(track_keys[i]) < t) i++;
      if (i >= n) return make_word(last, last, 0, 1'b1);
      if (i == 0) return make_word(0, 0, 0, 1'b0);
      k0 = longint'(track_keys[i-1]);
      k1 = longint'(track_keys[i]);
      return make_word(i - 1, i, ((t - k0) <<< FRAC_BITS) / (k1 - k0), 1'b0);
   endfunction

   always @(posedge clock) begin
      sample_word_type want;
      longint          advanced;
      if (reset) begin
         track_time     = '0;
         looping        = 1'b0;
         key_count      = CSR_DATA_W'(1);
         expected_samples.delete();
         mismatch_count = 0;
         words_checked  = 0;
      end else begin
         // A result word can never belong to a tick taken at the same edge.
         if (rsp_valid) begin
            if (expected_samples.size() == 0) begin
               flag_mismatch("result word arrived with none expected");
            end else begin
               want = expected_samples.pop_front();
               if (rsp_first_key !== want.first_key)
                  flag_mismatch($sformatf("first_key got %0d, expected %0d",
                                          rsp_first_key, want.first_key));
               if (rsp_second_key !== want.second_key)
                  flag_mismatch($sformatf("second_key got %0d, expected %0d",
                                          rsp_second_key, want.second_key));
               if (rsp_fraction !== want.fraction)
                  flag_mismatch($sformatf("fraction got %0d, expected %0d",
                                          rsp_fraction, want.fraction));
               if (rsp_clamped !== want.clamped)
                  flag_mismatch($sformatf("clamped got %0b, expected %0b",
                                          rsp_clamped, want.clamped));
               words_checked++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PLAYBACK_MODE: looping = csr_wdata[0];
               CSR_KEY_COUNT:     key_count = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_opcode)
               OPC_LOAD: track_keys[req_key_index] = req_key_time;
               OPC_REWIND: track_time = '0;
               OPC_TICK: begin
                  expected_samples.push_back(sample_track());
                  advanced = longint'(track_time) + longint'(req_delta_time);
                  if (advanced > longint'(32'sh7FFF_FFFF)) advanced = longint'(32'sh7FFF_FFFF);
                  track_time = advanced[TIME_W-1:0];
               end
               default: ;
            endcase
         end
      end
      pending_words = expected_samples.size();
   end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kis_pkg::*;

   localparam opcode_type OPC_UNUSED  = 2'd3;
   localparam int         ITEM_TARGET = 1200;
   localparam int         CYCLE_LIMIT = 3_000_000;
   localparam int         IDLE_SETTLE = 64;
   localparam int         END_SETTLE  = 1000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   opcode_type               req_opcode = OPC_LOAD;
   logic [KEY_IDX_W-1:0]     req_key_index = '0;
   logic signed [TIME_W-1:0] req_key_time = '0;
   logic [DELTA_W-1:0]       req_delta_time = '0;
   logic                     rsp_valid;
   logic [KEY_IDX_W-1:0]     rsp_first_key;
   logic [KEY_IDX_W-1:0]     rsp_second_key;
   logic [FRAC_W-1:0]        rsp_fraction;
   logic                     rsp_clamped;
   logic                     csr_we = 1'b0;
   csr_index_type            csr_index = CSR_PLAYBACK_MODE;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int pending_words;
   int mismatch_count;
   int words_checked;
   int cycles;
   int words_sent = 0;
   int ticks_sent = 0;
   int setups = 0;
   bit no_idle = 1'b0;
   bit slot_loaded [KEYS];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   keyframe_interval_sampler_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_key_index  (req_key_index),
      .req_key_time   (req_key_time),
      .req_delta_time (req_delta_time),
      .rsp_valid      (rsp_valid),
      .rsp_first_key  (rsp_first_key),
      .rsp_second_key (rsp_second_key),
      .rsp_fraction   (rsp_fraction),
      .rsp_clamped    (rsp_clamped),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   keyframe_interval_sampler_checker sampler_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_key_index  (req_key_index),
      .req_key_time   (req_key_time),
      .req_delta_time (req_delta_time),
      .rsp_valid      (rsp_valid),
      .rsp_first_key  (rsp_first_key),
      .rsp_second_key (rsp_second_key),
      .rsp_fraction   (rsp_fraction),
      .rsp_clamped    (rsp_clamped),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending_words  (pending_words),
      .mismatch_count (mismatch_count),
      .words_checked  (words_checked)
   );

   // Start stays high from one word to the next when no gap is drawn, so that
   // it is never lowered and raised in the same time step.
   task automatic send_word(input opcode_type op, input logic [KEY_IDX_W-1:0] slot,
                            input logic [TIME_W-1:0] ktime, input logic [DELTA_W-1:0] delta);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_key_index  <= slot;
      req_key_time   <= ktime;
      req_delta_time <= delta;
      do @(posedge clock); while (busy);
      if (op != OPC_UNUSED) words_sent++;
      if (op == OPC_TICK) ticks_sent++;
      if (op == OPC_LOAD) slot_loaded[slot] = 1'b1;
   endtask

   // Waits until every predicted result word has come back, then lets the
   // trailing loads and rewinds retire.
   task automatic hold_until_drained(input int settle);
      start <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_setup(input bit mode, input logic [CSR_DATA_W-1:0] count);
      logic [CSR_DATA_W-2:0] junk;
      junk = (CSR_DATA_W-1)'($urandom());
      csr_we    <= 1'b1;
      csr_index <= CSR_PLAYBACK_MODE;
      csr_wdata <= {junk, mode};
      @(posedge clock);
      csr_index <= CSR_KEY_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_we <= 1'b0;
      setups++;
   endtask

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles with %0d result words outstanding",
               cycles, pending_words);
      $display("keyframe_interval_sampler_top verification failed");
      $finish;
   end

   initial begin
      int                       n;
      int                       phase;
      int                       shape;
      int                       choice;
      int                       tick_quota;
      bit                       mode;
      bit                       fresh;
      logic [CSR_DATA_W-1:0]    count;
      logic signed [TIME_W-1:0] key_at;
      logic [DELTA_W-1:0]       delta;
      logic [DELTA_W-1:0]       delta_max;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme key times, a full-scale fraction, saturation of the
      // play time, a dropped opcode, clamping at both track ends.
      write_setup(1'b0, 9'd4);
      send_word(OPC_LOAD, 8'd0, 32'h8000_0000, '0);
      send_word(OPC_LOAD, 8'd1, 32'h0000_0000, '0);
      send_word(OPC_LOAD, 8'd2, 32'h0001_0000, '0);
      send_word(OPC_LOAD, 8'd3, 32'h7FFF_FFFF, '0);
      send_word(OPC_TICK, '0, '0, '0);
      send_word(OPC_TICK, '0, '0, 31'h0000_8000);
      send_word(OPC_TICK, '0, '0, 31'h7FFF_FFFF);
      send_word(OPC_TICK, '0, '0, '0);
      send_word(OPC_REWIND, '0, '0, '0);
      send_word(OPC_UNUSED, '1, '1, '1);
      send_word(OPC_LOAD, 8'd0, 32'h0000_8000, '0);
      send_word(OPC_TICK, '0, '0, 31'h0000_4000);
      send_word(OPC_TICK, '0, '0, 31'h0000_4000);
      send_word(OPC_TICK, '0, '0, 31'h0000_0001);

      // Looping: a wrap from a negative offset, then a time right on key 0.
      hold_until_drained(IDLE_SETTLE);
      write_setup(1'b1, 9'd4);
      send_word(OPC_LOAD, 8'd1, 32'h0001_0000, '0);
      send_word(OPC_TICK, '0, '0, '0);
      send_word(OPC_REWIND, '0, '0, '0);
      send_word(OPC_TICK, '0, '0, '0);
      send_word(OPC_LOAD, 8'd0, 32'h0000_0000, '0);
      send_word(OPC_REWIND, '0, '0, '0);
      send_word(OPC_TICK, '0, '0, 31'h0001_0000);

      // Looping over a single key leaves a track of zero length.
      hold_until_drained(IDLE_SETTLE);
      write_setup(1'b1, 9'd1);
      send_word(OPC_TICK, '0, '0, '0);

      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         hold_until_drained(IDLE_SETTLE);
         choice = $urandom_range(0, 9);
         mode   = 1'($urandom_range(0, 1));
         count  = CSR_DATA_W'($urandom_range(2, 16));
         case (phase)
            0: begin mode = 1'b1; count = 9'd511; end
            1: begin mode = 1'b0; count = 9'd256; end
            2: begin mode = 1'b0; count = 9'd0; end
            3: begin mode = 1'b1; count = 9'd1; end
            default: if (choice == 0) count = CSR_DATA_W'($urandom_range(0, 1));
         endcase
         if (count == 0) begin
            n = 1;
         end else if (count > KEYS) begin
            n = KEYS;
         end else begin
            n = int'(count);
         end
         write_setup(mode, count);
         no_idle = ($urandom_range(0, 3) == 0);

         // The full table loaded for the first phase is reused by the second,
         // so only one of the slow 256-key loads is paid for.
         fresh = (phase != 1) && ($urandom_range(0, 4) != 0);
         for (int s = 0; s < n; s++) begin
            if (!slot_loaded[s]) fresh = 1'b1;
         end
         if (fresh) begin
            shape  = $urandom_range(0, 9);
            key_at = $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
            for (int s = 0; s < n; s++) begin
               if (shape == 9) begin
                  send_word(OPC_LOAD, KEY_IDX_W'(s), $urandom(), DELTA_W'($urandom()));
               end else begin
                  send_word(OPC_LOAD, KEY_IDX_W'(s), key_at, DELTA_W'($urandom()));
                  if (shape == 7) begin
                     key_at += $urandom_range(0, 32'h2_0000);
                  end else if (shape != 8) begin
                     key_at += $urandom_range(1, 32'h3_0000);
                  end
               end
            end
         end
         send_word(OPC_REWIND, KEY_IDX_W'($urandom()), $urandom(), DELTA_W'($urandom()));

         tick_quota = (n > 32) ? 12 : $urandom_range(30, 70);
         delta_max  = DELTA_W'((n + 1) * 32'h8000);
         while (tick_quota > 0) begin
            choice = $urandom_range(0, 99);
            if (choice < 2) hold_until_drained(1);
            if (choice < 80) begin
               case ($urandom_range(0, 19))
                  0:       delta = '0;
                  1:       delta = '1;
                  2:       delta = DELTA_W'($urandom());
                  default: delta = DELTA_W'($urandom_range(0, delta_max));
               endcase
               send_word(OPC_TICK, KEY_IDX_W'($urandom()), $urandom(), delta);
               tick_quota--;
            end else if (choice < 88) begin
               send_word(OPC_REWIND, KEY_IDX_W'($urandom()), $urandom(),
                         DELTA_W'($urandom()));
            end else if (choice < 96) begin
               send_word(OPC_LOAD, KEY_IDX_W'($urandom()), $urandom(),
                         DELTA_W'($urandom()));
            end else begin
               send_word(OPC_UNUSED, KEY_IDX_W'($urandom()), $urandom(),
                         DELTA_W'($urandom()));
            end
         end
         phase++;
      end

      hold_until_drained(END_SETTLE);
      $display("Drove %0d words (%0d ticks) over %0d register setups; %0d result words compared.",
               words_sent, ticks_sent, setups, words_checked);
      $display("Setups covered one-shot and looping playback, key counts 0 to 511, %0d errors.",
               mismatch_count);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("keyframe_interval_sampler_top verification clean");
      end else begin
         $display("keyframe_interval_sampler_top verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ keyframe_interval_sampler_top.f @@
+incdir+rtl
rtl/kis_pkg.sv
rtl/kis_front.sv
rtl/kis_queue.sv
rtl/kis_divider.sv
rtl/kis_back.sv
rtl/keyframe_interval_sampler_top.sv
tb/keyframe_interval_sampler_checker.sv
tb/tb_top.sv
